// ===== src/srt_pkg.sv =====
// Shared types and constants for the segment reassembly tracker.
// No dependencies.
package srt_pkg;

    localparam int NUM_CONTEXTS_DEF = 8;
    localparam int MAX_SEGS_DEF     = 16;

    localparam logic [7:0]  HDR_RESET = 8'd18;
    localparam logic [19:0] TOTAL_MAX = 20'hFFFFF;
    localparam logic [4:0]  COUNT_MAX = 5'd31;

    typedef enum logic [2:0] {
        ST_PENDING     = 3'd0,
        ST_WHOLE       = 3'd1,
        ST_REASSEMBLED = 3'd2,
        ST_SHORT       = 3'd3,
        ST_RANGE       = 3'd4,
        ST_FULL        = 3'd5,
        ST_TOO_SHORT   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_UPDATE,
        S_EVAL,
        S_SUM,
        S_FIN,
        S_DONE
    } t_state;

    // command to the shared summing unit
    typedef struct packed {
        logic load;
        logic add;
    } t_sum_cmd;

endpackage

// ===== src/srt_if.sv =====
// Valid/ready channel interfaces for the segment reassembly tracker.
// No dependencies.
interface srt_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  sequence_number;
    logic [6:0]  segment_index;
    logic        more_flag;
    logic [15:0] seg_bytes;

    modport source (output valid, sequence_number, segment_index, more_flag,
                    seg_bytes, input ready);
    modport sink (input valid, sequence_number, segment_index, more_flag,
                  seg_bytes, output ready);
endinterface

interface srt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [19:0] total_length;
    logic [7:0]  done_sequence;
    logic [4:0]  segment_count;

    modport source (output valid, status, total_length, done_sequence,
                    segment_count, input ready);
    modport sink (input valid, status, total_length, done_sequence,
                  segment_count, output ready);
endinterface

// ===== src/srt_len_mem.sv =====
// Segment length store: one write port, one registered read port.
// Depends on nothing.
module srt_len_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);
    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/srt_sum_unit.sv =====
// Shared accumulator: strips the header from each non-first segment,
// adds it with saturation and flags segments shorter than the header.
// Depends on srt_pkg.
module srt_sum_unit (
    input  logic              i_clk,
    input  srt_pkg::t_sum_cmd i_cmd,
    input  logic [15:0]       i_len,
    input  logic [7:0]        i_hdr,
    output logic [19:0]       o_total,
    output logic              o_too_short
);
    logic [19:0] r_total;
    logic        r_too_short;
    logic [20:0] sum;
    logic        short_seg;

    assign short_seg = i_len < {8'h00, i_hdr};
    assign sum = {1'b0, r_total} + 21'(i_len - {8'h00, i_hdr});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_total     <= {4'h0, i_len};
            r_too_short <= 1'b0;
        end else if (i_cmd.add) begin
            if (short_seg) begin
                r_too_short <= 1'b1;
            end else if (sum > {1'b0, srt_pkg::TOTAL_MAX}) begin
                r_total <= srt_pkg::TOTAL_MAX;
            end else begin
                r_total <= sum[19:0];
            end
        end
    end

    assign o_total     = r_total;
    assign o_too_short = r_too_short;
endmodule

// ===== src/segment_reassembly_tracker.sv =====
// Each item is checked first; short, unsegmented or out-of-range items go
// straight to the result. Others scan the contexts (one compare per cycle)
// for a match, else allocate the lowest free one or report table full, then
// update it; on completion the stored lengths are read and summed (one per
// cycle) in the shared summing unit. A new item is taken only in idle, once
// the previous result has gone to the output register. Synchronous active-low reset
// frees all contexts and sets header_bytes to 18; the length store is not cleared.
module segment_reassembly_tracker #(
    parameter int NUM_CONTEXTS = srt_pkg::NUM_CONTEXTS_DEF,
    parameter int MAX_SEGS     = srt_pkg::MAX_SEGS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    srt_in_if.sink     i_in,
    srt_out_if.source  o_out
);
    localparam int CIW   = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int SW    = $clog2(MAX_SEGS);
    localparam int CW    = $clog2(MAX_SEGS + 1);
    localparam int DEPTH = NUM_CONTEXTS * MAX_SEGS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    srt_pkg::t_state r_state, n_state;

    logic [7:0]  r_hdr;
    logic [7:0]  r_seq;
    logic [6:0]  r_seg;
    logic        r_more;
    logic [15:0] r_len;

    logic [CIW-1:0] r_ci, r_free_idx, r_c;
    logic           r_free_ok;
    logic [CW-1:0]  r_i;
    logic           r_rd_valid, r_rd_first;

    logic                r_active [NUM_CONTEXTS];
    logic [7:0]          r_cseq   [NUM_CONTEXTS];
    logic [MAX_SEGS-1:0] r_bitmap [NUM_CONTEXTS];
    logic [CW-1:0]       r_hpo    [NUM_CONTEXTS];
    logic                r_last   [NUM_CONTEXTS];
    logic [CW-1:0]       r_pcnt   [NUM_CONTEXTS];

    logic [2:0]  r_res_status;
    logic [19:0] r_res_total;
    logic [4:0]  r_res_cnt;

    logic        r_ovalid;
    logic [2:0]  r_o_status;
    logic [19:0] r_o_total;
    logic [7:0]  r_o_seq;
    logic [4:0]  r_o_cnt;

    logic chk_short, chk_whole, chk_range;
    logic hit, free_now, scan_last, complete, out_free;
    logic [SW-1:0] segi;
    logic [CW-1:0] seg_p1;

    srt_pkg::t_sum_cmd sum_cmd;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [15:0] mem_rdata;
    logic [19:0] sum_total;
    logic        sum_too_short;

    assign chk_short = r_len < {8'h00, r_hdr};
    assign chk_whole = !r_more && (r_seg == 7'd0);
    assign chk_range = int'(r_seg) >= MAX_SEGS;
    assign hit       = r_active[r_ci] && (r_cseq[r_ci] == r_seq);
    assign free_now  = !r_active[r_ci];
    assign scan_last = r_ci == CIW'(NUM_CONTEXTS - 1);
    assign complete  = r_last[r_c] && (r_pcnt[r_c] == r_hpo[r_c]);
    assign out_free  = !r_ovalid || o_out.ready;
    assign segi      = r_seg[SW-1:0];
    assign seg_p1    = CW'(r_seg) + CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srt_pkg::S_IDLE: begin
                if (i_in.valid) n_state = srt_pkg::S_CHECK;
            end
            srt_pkg::S_CHECK: begin
                if (chk_short || chk_whole || chk_range) n_state = srt_pkg::S_DONE;
                else n_state = srt_pkg::S_SCAN;
            end
            srt_pkg::S_SCAN: begin
                if (hit || (scan_last && (r_free_ok || free_now))) begin
                    n_state = srt_pkg::S_UPDATE;
                end else if (scan_last) begin
                    n_state = srt_pkg::S_DONE;
                end
            end
            srt_pkg::S_UPDATE: n_state = srt_pkg::S_EVAL;
            srt_pkg::S_EVAL: begin
                n_state = complete ? srt_pkg::S_SUM : srt_pkg::S_DONE;
            end
            srt_pkg::S_SUM: begin
                if (r_i == r_hpo[r_c]) n_state = srt_pkg::S_FIN;
            end
            srt_pkg::S_FIN: n_state = srt_pkg::S_DONE;
            srt_pkg::S_DONE: begin
                if (out_free) n_state = srt_pkg::S_IDLE;
            end
            default: n_state = srt_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_in.ready   = r_state == srt_pkg::S_IDLE;
        mem_we       = (r_state == srt_pkg::S_UPDATE) && !r_bitmap[r_c][segi];
        mem_waddr    = AW'(r_c) * AW'(MAX_SEGS) + AW'(segi);
        mem_raddr    = AW'(r_c) * AW'(MAX_SEGS) + AW'(r_i);
        sum_cmd.load = r_rd_valid && r_rd_first;
        sum_cmd.add  = r_rd_valid && !r_rd_first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= srt_pkg::S_IDLE;
            r_hdr      <= srt_pkg::HDR_RESET;
            r_rd_valid <= 1'b0;
            r_ovalid   <= 1'b0;
            for (int k = 0; k < NUM_CONTEXTS; k++) begin
                r_active[k] <= 1'b0;
                r_cseq[k]   <= '0;
                r_bitmap[k] <= '0;
                r_hpo[k]    <= '0;
                r_last[k]   <= 1'b0;
                r_pcnt[k]   <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_rd_valid <= (r_state == srt_pkg::S_SUM) && (r_i < r_hpo[r_c]);
            r_rd_first <= r_i == '0;
            if (i_cfg_we) r_hdr <= i_cfg_wdata;
            if ((r_state == srt_pkg::S_DONE) && out_free) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;

            case (r_state)
                srt_pkg::S_IDLE: begin
                    if (i_in.valid) begin
                        r_seq  <= i_in.sequence_number;
                        r_seg  <= i_in.segment_index;
                        r_more <= i_in.more_flag;
                        r_len  <= i_in.seg_bytes;
                    end
                end
                srt_pkg::S_CHECK: begin
                    r_ci         <= '0;
                    r_free_ok    <= 1'b0;
                    if (chk_short) begin
                        r_res_status <= srt_pkg::ST_SHORT;
                        r_res_total  <= '0;
                        r_res_cnt    <= '0;
                    end else if (chk_whole) begin
                        r_res_status <= srt_pkg::ST_WHOLE;
                        r_res_total  <= {4'h0, r_len};
                        r_res_cnt    <= 5'd1;
                    end else begin
                        r_res_status <= srt_pkg::ST_RANGE;
                        r_res_total  <= '0;
                        r_res_cnt    <= '0;
                    end
                end
                srt_pkg::S_SCAN: begin
                    if (hit) begin
                        r_c <= r_ci;
                    end else if (scan_last) begin
                        if (r_free_ok || free_now) begin
                            // allocate lowest free context
                            r_c <= r_free_ok ? r_free_idx : r_ci;
                            r_active[r_free_ok ? r_free_idx : r_ci] <= 1'b1;
                            r_cseq[r_free_ok ? r_free_idx : r_ci]   <= r_seq;
                            r_bitmap[r_free_ok ? r_free_idx : r_ci] <= '0;
                            r_hpo[r_free_ok ? r_free_idx : r_ci]    <= '0;
                            r_last[r_free_ok ? r_free_idx : r_ci]   <= 1'b0;
                            r_pcnt[r_free_ok ? r_free_idx : r_ci]   <= '0;
                        end else begin
                            r_res_status <= srt_pkg::ST_FULL;
                        end
                    end else begin
                        if (free_now && !r_free_ok) begin
                            r_free_ok  <= 1'b1;
                            r_free_idx <= r_ci;
                        end
                        r_ci <= r_ci + CIW'(1);
                    end
                end
                srt_pkg::S_UPDATE: begin
                    if (!r_bitmap[r_c][segi]) begin
                        r_bitmap[r_c][segi] <= 1'b1;
                        r_pcnt[r_c]         <= r_pcnt[r_c] + CW'(1);
                        if (seg_p1 > r_hpo[r_c]) r_hpo[r_c] <= seg_p1;
                    end
                    if (!r_more) r_last[r_c] <= 1'b1;
                end
                srt_pkg::S_EVAL: begin
                    r_i          <= '0;
                    r_res_status <= srt_pkg::ST_PENDING;
                end
                srt_pkg::S_SUM: begin
                    if (r_i < r_hpo[r_c]) r_i <= r_i + CW'(1);
                end
                srt_pkg::S_FIN: begin
                    if (sum_too_short) begin
                        r_res_status <= srt_pkg::ST_TOO_SHORT;
                    end else begin
                        r_res_status <= srt_pkg::ST_REASSEMBLED;
                        r_res_total  <= sum_total;
                        r_res_cnt    <= (int'(r_hpo[r_c]) > 31) ? srt_pkg::COUNT_MAX
                                                             : 5'(r_hpo[r_c]);
                    end
                    r_active[r_c] <= 1'b0;
                    r_cseq[r_c]   <= '0;
                    r_bitmap[r_c] <= '0;
                    r_hpo[r_c]    <= '0;
                    r_last[r_c]   <= 1'b0;
                    r_pcnt[r_c]   <= '0;
                end
                srt_pkg::S_DONE: begin
                    if (out_free) begin
                        r_o_status <= r_res_status;
                        r_o_total  <= r_res_total;
                        r_o_seq    <= r_seq;
                        r_o_cnt    <= r_res_cnt;
                    end
                end
                default: ;
            endcase
        end
    end

    srt_len_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_len_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_len),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    srt_sum_unit u_sum (
        .i_clk       (i_clk),
        .i_cmd       (sum_cmd),
        .i_len       (mem_rdata),
        .i_hdr       (r_hdr),
        .o_total     (sum_total),
        .o_too_short (sum_too_short)
    );

    assign o_out.valid         = r_ovalid;
    assign o_out.status        = r_o_status;
    assign o_out.total_length  = r_o_total;
    assign o_out.done_sequence = r_o_seq;
    assign o_out.segment_count = r_o_cnt;
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for segment_reassembly_tracker: random and directed segment headers,
// with results checked against an internal reassembly predictor.
// Depends on srt_pkg, srt_in_if, srt_out_if and segment_reassembly_tracker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCTX = 8;
    localparam int NSEG = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [7:0]  seq;
        logic [6:0]  seg;
        logic        more;
        logic [15:0] len;
    } t_hdr;

    typedef struct packed {
        srt_pkg::t_status status;
        logic [19:0] total;
        logic [7:0]  seq;
        logic [4:0]  count;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = '0;

    srt_in_if  hdr_ch ();
    srt_out_if res_ch ();

    segment_reassembly_tracker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (hdr_ch.sink),
        .o_out       (res_ch.source)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predictor state
    logic [7:0]  hdr_bytes;
    logic        ctx_busy  [NCTX];
    logic [7:0]  ctx_seq   [NCTX];
    logic [NSEG-1:0] ctx_map [NCTX];
    int          ctx_top   [NCTX];
    logic        ctx_last  [NCTX];
    int          ctx_cnt   [NCTX];
    logic [15:0] ctx_len   [NCTX][NSEG];

    t_hdr     pending_hdrs[$];
    t_verdict expected_verdicts[$];
    int  errors = 0;
    bit  idle_en = 1'b1;
    bit  hold_tx = 1'b0;
    bit  hdr_taken = 1'b0;
    int  tx_gap = 0;
    int  rx_gap = 0;
    int  quiet_cycles = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic void clear_ctx(int c);
        ctx_busy[c] = 1'b0;
        ctx_seq[c]  = '0;
        ctx_map[c]  = '0;
        ctx_top[c]  = 0;
        ctx_last[c] = 1'b0;
        ctx_cnt[c]  = 0;
    endfunction

    function automatic t_verdict reassemble(t_hdr h);
        t_verdict v;
        int c;
        int hit;
        int total;
        v = '{srt_pkg::ST_PENDING, 20'd0, h.seq, 5'd0};
        hit = -1;
        if (h.len < hdr_bytes) begin
            v.status = srt_pkg::ST_SHORT;
            return v;
        end
        if (!h.more && h.seg == 0) begin
            v.status = srt_pkg::ST_WHOLE;
            v.total = 20'(h.len);
            v.count = 5'd1;
            return v;
        end
        if (h.seg >= NSEG) begin
            v.status = srt_pkg::ST_RANGE;
            return v;
        end
        for (c = 0; c < NCTX; c++)
            if (hit < 0 && ctx_busy[c] && ctx_seq[c] == h.seq) hit = c;
        for (c = 0; c < NCTX; c++)
            if (hit < 0 && !ctx_busy[c]) begin
                clear_ctx(c);
                ctx_busy[c] = 1'b1;
                ctx_seq[c] = h.seq;
                hit = c;
            end
        if (hit < 0) begin
            v.status = srt_pkg::ST_FULL;
            return v;
        end
        c = hit;
        if (!ctx_map[c][h.seg]) begin
            ctx_map[c][h.seg] = 1'b1;
            ctx_len[c][h.seg] = h.len;
            ctx_cnt[c]++;
            if (h.seg + 1 > ctx_top[c]) ctx_top[c] = h.seg + 1;
        end
        if (!h.more) ctx_last[c] = 1'b1;
        if (!(ctx_last[c] && ctx_cnt[c] == ctx_top[c])) return v;
        total = ctx_len[c][0];
        for (int i = 1; i < ctx_top[c]; i++) begin
            if (ctx_len[c][i] < hdr_bytes) begin
                clear_ctx(c);
                v.status = srt_pkg::ST_TOO_SHORT;
                return v;
            end
            total += ctx_len[c][i] - hdr_bytes;
            if (total > 32'hFFFFF) total = 32'hFFFFF;
        end
        v.status = srt_pkg::ST_REASSEMBLED;
        v.total = 20'(total);
        v.count = 5'(ctx_top[c]);
        clear_ctx(c);
        return v;
    endfunction

    // remembers whether the item on the bus was taken at the last rising edge
    always @(posedge i_clk) begin
        hdr_taken <= hdr_ch.valid && hdr_ch.ready;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            hdr_ch.valid <= 1'b0;
        end else if (!hdr_ch.valid || hdr_taken) begin
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                hdr_ch.valid <= 1'b0;
            end else if (pending_hdrs.size() > 0 && !hold_tx) begin
                if (idle_en && $urandom_range(0, 7) == 0) begin
                    tx_gap <= $urandom_range(1, 13);
                    hdr_ch.valid <= 1'b0;
                end else begin
                    t_hdr h;
                    h = pending_hdrs.pop_front();
                    hdr_ch.valid <= 1'b1;
                    hdr_ch.sequence_number <= h.seq;
                    hdr_ch.segment_index <= h.seg;
                    hdr_ch.more_flag <= h.more;
                    hdr_ch.seg_bytes <= h.len;
                end
            end else begin
                hdr_ch.valid <= 1'b0;
            end
        end
    end

    initial begin
        hdr_ch.valid = 1'b0;
        hdr_ch.sequence_number = '0;
        hdr_ch.segment_index = '0;
        hdr_ch.more_flag = 1'b0;
        hdr_ch.seg_bytes = '0;
        res_ch.ready = 1'b0;
    end

    always @(negedge i_clk) begin
        if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            res_ch.ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(1, 13);
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    // monitor: predict on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((hdr_ch.valid && hdr_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (hdr_ch.valid && hdr_ch.ready) begin
                t_hdr h;
                h = '{hdr_ch.sequence_number, hdr_ch.segment_index, hdr_ch.more_flag,
                      hdr_ch.seg_bytes};
                expected_verdicts.push_back(reassemble(h));
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_verdicts.size() == 0) begin
                    report("unexpected result", res_ch.status, 0);
                end else begin
                    t_verdict e;
                    e = expected_verdicts.pop_front();
                    if (res_ch.status !== e.status) report("status", res_ch.status, e.status);
                    if (res_ch.total_length !== e.total)
                        report("total_length", res_ch.total_length, e.total);
                    if (res_ch.done_sequence !== e.seq)
                        report("done_sequence", res_ch.done_sequence, e.seq);
                    if (res_ch.segment_count !== e.count)
                        report("segment_count", res_ch.segment_count, e.count);
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic t_hdr mk(int seq, int seg, int more, int len);
        t_hdr h;
        h.seq = 8'(seq);
        h.seg = 7'(seg);
        h.more = 1'(more);
        h.len = 16'(len);
        return h;
    endfunction

    // closes every open context: fills the gaps, then marks the last segment
    task automatic flush_contexts();
        for (int c = 0; c < NCTX; c++)
            if (ctx_busy[c]) begin
                for (int s = 0; s < ctx_top[c]; s++)
                    if (!ctx_map[c][s]) pending_hdrs.push_back(mk(ctx_seq[c], s, 1, 255));
                if (!ctx_last[c])
                    pending_hdrs.push_back(mk(ctx_seq[c],
                        (ctx_top[c] < NSEG) ? ctx_top[c] : ctx_top[c] - 1, 0, 255));
            end
    endtask

    // one message split into n segments, shuffled, with occasional duplicate
    task automatic add_message(int seq, int n, int maxlen);
        t_hdr parts[$];
        for (int s = 0; s < n; s++)
            parts.push_back(mk(seq, s, s != n - 1,
                $urandom_range(0, 15) == 0 ? $urandom_range(0, 65535)
                                           : $urandom_range(hdr_bytes, maxlen)));
        if ($urandom_range(0, 4) == 0) parts.push_back(parts[$urandom_range(0, n - 1)]);
        parts.shuffle();
        foreach (parts[k]) pending_hdrs.push_back(parts[k]);
    endtask

    task automatic drain(int extra);
        while (pending_hdrs.size() > 0 || hdr_ch.valid || expected_verdicts.size() > 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic set_hdr(logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        hdr_bytes = val;
    endtask

    initial begin
        int cfgs[4];
        int n;
        cfgs = '{1, 255, 40, 18};
        hdr_bytes = srt_pkg::HDR_RESET;
        for (int c = 0; c < NCTX; c++) begin
            clear_ctx(c);
            for (int s = 0; s < NSEG; s++) ctx_len[c][s] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset header length
        pending_hdrs.push_back(mk(0, 0, 0, 17));
        pending_hdrs.push_back(mk(255, 0, 0, 65535));
        pending_hdrs.push_back(mk(1, 127, 1, 100));
        pending_hdrs.push_back(mk(2, 16, 0, 100));
        pending_hdrs.push_back(mk(3, 0, 1, 65535));
        pending_hdrs.push_back(mk(3, 0, 1, 100));
        for (int s = 1; s < 16; s++) pending_hdrs.push_back(mk(3, s, s != 15, 65535));
        for (int q = 10; q < 19; q++) pending_hdrs.push_back(mk(q, 1, 1, 50));
        pending_hdrs.push_back(mk(10, 0, 0, 50));
        pending_hdrs.push_back(mk(10, 0, 1, 50));
        for (int q = 11; q < 18; q++) pending_hdrs.push_back(mk(q, 2, 0, 5));
        drain(40);
        // sender holds off with every result in before the next burst
        hold_tx = 1'b1;
        for (int q = 11; q < 18; q++) pending_hdrs.push_back(mk(q, 0, 1, 30));
        repeat (20) @(posedge i_clk);
        hold_tx = 1'b0;
        drain(40);

        foreach (cfgs[k]) begin
            set_hdr(8'(cfgs[k]));
            n = 0;
            while (n < 170) begin
                if ($urandom_range(0, 5) == 0) begin
                    pending_hdrs.push_back(mk($urandom_range(0, 255), $urandom_range(0, 127),
                        $urandom_range(0, 1), $urandom_range(0, 65535)));
                    n++;
                end else begin
                    int segs;
                    segs = $urandom_range(0, 7) == 0 ? $urandom_range(1, 16)
                                                     : $urandom_range(1, 4);
                    add_message($urandom_range(0, 15), segs,
                                $urandom_range(0, 3) == 0 ? 65535 : 300);
                    n += segs;
                end
            end
            if (k == 3) idle_en = 1'b0;
            drain(40);
            // complete leftover contexts so the next header size starts clean
            flush_contexts();
            drain(40);
        end

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/srt_pkg.sv
src/srt_if.sv
src/srt_len_mem.sv
src/srt_sum_unit.sv
src/segment_reassembly_tracker.sv
tb/sv/tb_top.sv
